// ===== rtl/core/qmtm_pkg.sv =====
package qmtm_pkg;

	// fixed point one and rounding half
	localparam logic [17:0] ONE_Q16    = 18'd65536;
	localparam logic [24:0] ROUND_HALF = 25'd32768;

	// register indexes of the configuration port
	localparam logic [2:0] CFG_TILT_STEP        = 3'd0;
	localparam logic [2:0] CFG_POWER_STEP_SMALL = 3'd1;
	localparam logic [2:0] CFG_POWER_STEP_LARGE = 3'd2;
	localparam logic [2:0] CFG_POWER_MAX        = 3'd3;
	localparam logic [2:0] CFG_GAIN_LINEAR      = 3'd4;
	localparam logic [2:0] CFG_GAIN_DERIVATIVE  = 3'd5;

	// register reset values
	localparam logic [16:0] RST_TILT_STEP        = 17'd1311;
	localparam logic [7:0]  RST_POWER_STEP_SMALL = 8'd1;
	localparam logic [7:0]  RST_POWER_STEP_LARGE = 8'd5;
	localparam logic [7:0]  RST_POWER_MAX        = 8'd100;
	localparam logic [15:0] RST_GAIN_LINEAR      = 16'd1311;
	localparam logic [15:0] RST_GAIN_DERIVATIVE  = 16'd2621;

	// request kinds
	localparam logic REQ_CMD   = 1'b0;
	localparam logic REQ_ACCEL = 1'b1;

	// command keys
	localparam logic [7:0] KEY_1       = 8'h31;
	localparam logic [7:0] KEY_2       = 8'h32;
	localparam logic [7:0] KEY_3       = 8'h33;
	localparam logic [7:0] KEY_4       = 8'h34;
	localparam logic [7:0] KEY_5       = 8'h35;
	localparam logic [7:0] KEY_6       = 8'h36;
	localparam logic [7:0] KEY_7       = 8'h37;
	localparam logic [7:0] KEY_8       = 8'h38;
	localparam logic [7:0] KEY_9       = 8'h39;
	localparam logic [7:0] KEY_PWR_OFF = 8'h5A; // Z
	localparam logic [7:0] KEY_PWR_DNL = 8'h7A; // z
	localparam logic [7:0] KEY_PWR_DNS = 8'h78; // x
	localparam logic [7:0] KEY_PWR_UPS = 8'h63; // c
	localparam logic [7:0] KEY_PWR_UPL = 8'h76; // v
	localparam logic [7:0] KEY_PWR_MAX = 8'h56; // V

	typedef struct packed {
		logic [16:0] tilt_step;
		logic [7:0]  power_step_small;
		logic [7:0]  power_step_large;
		logic [7:0]  power_max;
		logic [15:0] gain_linear;
		logic [15:0] gain_derivative;
	} cfg_t;

	typedef struct packed {
		logic signed [17:0] tilt_x;
		logic signed [17:0] tilt_y;
		logic [7:0]         power;
	} mix_state_t;

	// factor of the motor lowered by negative tilt
	function automatic logic [16:0] factor_neg(input logic signed [17:0] t);
		logic [17:0] s;
		begin
			s = ONE_Q16 + t;
			return t[17] ? s[16:0] : ONE_Q16[16:0];
		end
	endfunction

	// factor of the motor lowered by positive tilt
	function automatic logic [16:0] factor_pos(input logic signed [17:0] t);
		logic [17:0] s;
		begin
			s = ONE_Q16 - t;
			return (!t[17] && (t != 18'sd0)) ? s[16:0] : ONE_Q16[16:0];
		end
	endfunction

	// round(f * p) with f in Q16
	function automatic logic [7:0] drive_val(input logic [16:0] f, input logic [7:0] p);
		logic [24:0] prod;
		begin
			prod = 25'(f) * 25'(p) + ROUND_HALF;
			return prod[23:16];
		end
	endfunction

endpackage

// ===== rtl/core/qmtm_if.sv =====
interface qmtm_req_if #(parameter int ACCEL_BITS = 12);
	logic                         valid;
	logic                         ready;
	logic                         req_type;
	logic [7:0]                   cmd_byte;
	logic                         axis_sel;
	logic signed [ACCEL_BITS-1:0] accel_value;

	modport source (output valid, req_type, cmd_byte, axis_sel, accel_value, input ready);
	modport sink (input valid, req_type, cmd_byte, axis_sel, accel_value, output ready);
endinterface

interface qmtm_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] pwm_x1;
	logic [7:0] pwm_x2;
	logic [7:0] pwm_y1;
	logic [7:0] pwm_y2;
	logic [7:0] total_power;

	modport source (output valid, pwm_x1, pwm_x2, pwm_y1, pwm_y2, total_power,
		input ready);
	modport sink (input valid, pwm_x1, pwm_x2, pwm_y1, pwm_y2, total_power,
		output ready);
endinterface

// ===== rtl/core/quad_motor_tilt_mixer.sv =====
// Four-motor tilt and power mixer.
// Channel req takes one item per handshake: a command byte (req_type 0) or
// one accelerometer sample for the X or Y axis (req_type 1). Channel res
// gives one item per request with the four motor drives and the total power.
// Configuration goes through cfg_we / cfg_idx / cfg_data; the user must write it
// only while no item is in flight, as the block itself does not enforce this.
// Throughput: one item per cycle while res.ready holds. The tilt and power
// registers are updated once per item, so items may follow back to back.
// A request accepted passes the input register, the state update and the
// output register with the drive multipliers before its result shows.
// When the receiver stalls, the three stages fill up and req.ready drops only
// once all of them hold an item; the waiting result holds steady.
// Reset clears tilt, power, last samples and all valid flags, and loads the
// register defaults.
module quad_motor_tilt_mixer #(
	parameter int ACCEL_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	qmtm_req_if.sink    req,
	qmtm_res_if.source  res,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [16:0] cfg_data
);

	qmtm_pkg::cfg_t       cfg_q;
	qmtm_pkg::mix_state_t st;

	logic                         valid_s1, valid_s2, valid_s3;
	logic                         req_type_s1, axis_sel_s1;
	logic [7:0]                   cmd_byte_s1;
	logic signed [ACCEL_BITS-1:0] accel_value_s1;
	logic                         free_s3, free_s2, acc;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tilt_step        <= qmtm_pkg::RST_TILT_STEP;
			cfg_q.power_step_small <= qmtm_pkg::RST_POWER_STEP_SMALL;
			cfg_q.power_step_large <= qmtm_pkg::RST_POWER_STEP_LARGE;
			cfg_q.power_max        <= qmtm_pkg::RST_POWER_MAX;
			cfg_q.gain_linear      <= qmtm_pkg::RST_GAIN_LINEAR;
			cfg_q.gain_derivative  <= qmtm_pkg::RST_GAIN_DERIVATIVE;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				qmtm_pkg::CFG_TILT_STEP:        cfg_q.tilt_step        <= cfg_data;
				qmtm_pkg::CFG_POWER_STEP_SMALL: cfg_q.power_step_small <= cfg_data[7:0];
				qmtm_pkg::CFG_POWER_STEP_LARGE: cfg_q.power_step_large <= cfg_data[7:0];
				qmtm_pkg::CFG_POWER_MAX:        cfg_q.power_max        <= cfg_data[7:0];
				qmtm_pkg::CFG_GAIN_LINEAR:      cfg_q.gain_linear      <= cfg_data[15:0];
				qmtm_pkg::CFG_GAIN_DERIVATIVE:  cfg_q.gain_derivative  <= cfg_data[15:0];
				default: begin end
			endcase
		end
	end

	// pipeline flow control
	assign free_s3   = !valid_s3 || res.ready;
	assign free_s2   = !valid_s2 || free_s3;
	assign req.ready = !valid_s1 || free_s2;
	assign acc       = req.valid && req.ready;
	assign res.valid = valid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (acc)
				valid_s1 <= 1'b1;
			else if (free_s2)
				valid_s1 <= 1'b0;
			if (free_s2)
				valid_s2 <= valid_s1;
			if (free_s3)
				valid_s3 <= valid_s2;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (acc) begin
			req_type_s1    <= req.req_type;
			cmd_byte_s1    <= req.cmd_byte;
			axis_sel_s1    <= req.axis_sel;
			accel_value_s1 <= req.accel_value;
		end
	end

	qmtm_state #(
		.ACCEL_BITS(ACCEL_BITS)
	) u_state (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.upd        (valid_s1 && free_s2),
		.req_type   (req_type_s1),
		.cmd_byte   (cmd_byte_s1),
		.axis_sel   (axis_sel_s1),
		.accel_value(accel_value_s1),
		.st         (st)
	);

	qmtm_drive u_drive (
		.clk        (clk),
		.load       (valid_s2 && free_s3),
		.st         (st),
		.pwm_x1     (res.pwm_x1),
		.pwm_x2     (res.pwm_x2),
		.pwm_y1     (res.pwm_y1),
		.pwm_y2     (res.pwm_y2),
		.total_power(res.total_power)
	);

endmodule

// ===== rtl/core/qmtm_state.sv =====
module qmtm_state #(
	parameter int ACCEL_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  qmtm_pkg::cfg_t               cfg,
	input  logic                         upd,
	input  logic                         req_type,
	input  logic [7:0]                   cmd_byte,
	input  logic                         axis_sel,
	input  logic signed [ACCEL_BITS-1:0] accel_value,
	output qmtm_pkg::mix_state_t         st
);

	localparam int AW = ACCEL_BITS;
	localparam int SW = AW + 20;
	localparam logic signed [SW-1:0] SAT_POS = SW'(65536);
	localparam logic signed [SW-1:0] SAT_NEG = -SAT_POS;

	logic signed [17:0]   tilt_x_q, tilt_y_q;
	logic [7:0]           power_q;
	logic signed [AW-1:0] prev_x_q, prev_y_q;

	logic                 dx_inc, dx_dec, dy_inc, dy_dec, tilt_clr, pwr_en;
	logic signed [9:0]    pwr_inc;
	logic signed [9:0]    pwr_sum;
	logic [7:0]           pwr_next;
	logic signed [SW-1:0] step_ext, tx_ext, ty_ext, tx_cmd, ty_cmd;
	logic signed [AW-1:0] prev_sel;
	logic signed [AW:0]   diff;
	logic signed [AW+16:0] lin;
	logic signed [AW+17:0] der;
	logic signed [SW-1:0] adj, t_sel, t_acc;
	logic signed [17:0]   tx_cmd_sat, ty_cmd_sat, t_acc_sat;

	function automatic logic signed [17:0] sat_tilt(input logic signed [SW-1:0] v);
		begin
			if (v > SAT_POS)
				return SAT_POS[17:0];
			else if (v < SAT_NEG)
				return SAT_NEG[17:0];
			else
				return v[17:0];
		end
	endfunction

	// command decode
	always_comb begin
		dx_inc   = 1'b0;
		dx_dec   = 1'b0;
		dy_inc   = 1'b0;
		dy_dec   = 1'b0;
		tilt_clr = 1'b0;
		pwr_en   = 1'b0;
		pwr_inc  = 10'sd0;
		unique case (cmd_byte)
			qmtm_pkg::KEY_1: begin dx_dec = 1'b1; dy_dec = 1'b1; end
			qmtm_pkg::KEY_2: begin dy_dec = 1'b1; end
			qmtm_pkg::KEY_3: begin dx_inc = 1'b1; dy_dec = 1'b1; end
			qmtm_pkg::KEY_4: begin dx_dec = 1'b1; end
			qmtm_pkg::KEY_5: begin tilt_clr = 1'b1; end
			qmtm_pkg::KEY_6: begin dx_inc = 1'b1; end
			qmtm_pkg::KEY_7: begin dx_dec = 1'b1; dy_inc = 1'b1; end
			qmtm_pkg::KEY_8: begin dy_inc = 1'b1; end
			qmtm_pkg::KEY_9: begin dx_inc = 1'b1; dy_inc = 1'b1; end
			qmtm_pkg::KEY_PWR_OFF: begin
				pwr_en  = 1'b1;
				pwr_inc = -$signed({2'b00, cfg.power_max});
			end
			qmtm_pkg::KEY_PWR_DNL: begin
				pwr_en  = 1'b1;
				pwr_inc = -$signed({2'b00, cfg.power_step_large});
			end
			qmtm_pkg::KEY_PWR_DNS: begin
				pwr_en  = 1'b1;
				pwr_inc = -$signed({2'b00, cfg.power_step_small});
			end
			qmtm_pkg::KEY_PWR_UPS: begin
				pwr_en  = 1'b1;
				pwr_inc = $signed({2'b00, cfg.power_step_small});
			end
			qmtm_pkg::KEY_PWR_UPL: begin
				pwr_en  = 1'b1;
				pwr_inc = $signed({2'b00, cfg.power_step_large});
			end
			qmtm_pkg::KEY_PWR_MAX: begin
				pwr_en  = 1'b1;
				pwr_inc = $signed({2'b00, cfg.power_max});
			end
			default: begin end
		endcase
	end

	// tilt keys
	always_comb begin
		step_ext = $signed({{(SW-17){1'b0}}, cfg.tilt_step});
		tx_ext   = {{(SW-18){tilt_x_q[17]}}, tilt_x_q};
		ty_ext   = {{(SW-18){tilt_y_q[17]}}, tilt_y_q};
		tx_cmd   = tx_ext + (dx_inc ? step_ext : '0) - (dx_dec ? step_ext : '0);
		ty_cmd   = ty_ext + (dy_inc ? step_ext : '0) - (dy_dec ? step_ext : '0);
		tx_cmd_sat = sat_tilt(tx_cmd);
		ty_cmd_sat = sat_tilt(ty_cmd);
	end

	// power keys, clamp to 0..power_max
	always_comb begin
		pwr_sum = $signed({2'b00, power_q}) + pwr_inc;
		if (pwr_sum > $signed({2'b00, cfg.power_max}))
			pwr_next = cfg.power_max;
		else if (pwr_sum < 10'sd0)
			pwr_next = 8'd0;
		else
			pwr_next = pwr_sum[7:0];
	end

	// pd term of an accelerometer sample
	always_comb begin
		prev_sel = axis_sel ? prev_y_q : prev_x_q;
		diff     = {accel_value[AW-1], accel_value} - {prev_sel[AW-1], prev_sel};
		lin      = $signed({1'b0, cfg.gain_linear}) * accel_value;
		der      = $signed({1'b0, cfg.gain_derivative}) * diff;
		adj      = {{(SW-AW-17){lin[AW+16]}}, lin} + {{(SW-AW-18){der[AW+17]}}, der};
		t_sel    = axis_sel ? ty_ext : tx_ext;
		t_acc    = t_sel + adj;
		t_acc_sat = sat_tilt(t_acc);
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tilt_x_q <= '0;
			tilt_y_q <= '0;
			power_q  <= '0;
			prev_x_q <= '0;
			prev_y_q <= '0;
		end else if (upd) begin
			if (req_type == qmtm_pkg::REQ_ACCEL) begin
				if (axis_sel) begin
					tilt_y_q <= t_acc_sat;
					prev_y_q <= accel_value;
				end else begin
					tilt_x_q <= t_acc_sat;
					prev_x_q <= accel_value;
				end
			end else begin
				if (tilt_clr) begin
					tilt_x_q <= '0;
					tilt_y_q <= '0;
				end else begin
					tilt_x_q <= tx_cmd_sat;
					tilt_y_q <= ty_cmd_sat;
				end
				if (pwr_en)
					power_q <= pwr_next;
			end
		end
	end

	assign st.tilt_x = tilt_x_q;
	assign st.tilt_y = tilt_y_q;
	assign st.power  = power_q;

endmodule

// ===== rtl/core/qmtm_drive.sv =====
module qmtm_drive (
	input  logic                 clk,
	input  logic                 load,
	input  qmtm_pkg::mix_state_t st,
	output logic [7:0]           pwm_x1,
	output logic [7:0]           pwm_x2,
	output logic [7:0]           pwm_y1,
	output logic [7:0]           pwm_y2,
	output logic [7:0]           total_power
);

	logic [7:0] mx1_s3, mx2_s3, my1_s3, my2_s3, pwr_s3;

	// motor drives from the current tilt and power
	always_ff @(posedge clk) begin
		if (load) begin
			mx1_s3 <= qmtm_pkg::drive_val(qmtm_pkg::factor_neg(st.tilt_x), st.power);
			mx2_s3 <= qmtm_pkg::drive_val(qmtm_pkg::factor_pos(st.tilt_x), st.power);
			my1_s3 <= qmtm_pkg::drive_val(qmtm_pkg::factor_neg(st.tilt_y), st.power);
			my2_s3 <= qmtm_pkg::drive_val(qmtm_pkg::factor_pos(st.tilt_y), st.power);
			pwr_s3 <= st.power;
		end
	end

	assign pwm_x1      = mx1_s3;
	assign pwm_x2      = mx2_s3;
	assign pwm_y1      = my1_s3;
	assign pwm_y2      = my2_s3;
	assign total_power = pwr_s3;

endmodule

// ===== rtl/core/qmtm_checker.sv =====
module qmtm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] pwm_x1,
	input logic [7:0] pwm_x2,
	input logic [7:0] pwm_y1,
	input logic [7:0] pwm_y2,
	input logic [7:0] total_power
);

	// a stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result withdrawn while stalled");

	// no motor drives above the total power
	a_drive_le_power: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pwm_x1 <= total_power && pwm_x2 <= total_power
			&& pwm_y1 <= total_power && pwm_y2 <= total_power)
		else $error("motor drive above total power");

	// the side not lowered by the x tilt runs at full power
	a_x_full_side: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pwm_x1 == total_power || pwm_x2 == total_power)
		else $error("both x motors lowered");

	// the side not lowered by the y tilt runs at full power
	a_y_full_side: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pwm_y1 == total_power || pwm_y2 == total_power)
		else $error("both y motors lowered");

endmodule

bind quad_motor_tilt_mixer qmtm_checker u_qmtm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.pwm_x1     (res.pwm_x1),
	.pwm_x2     (res.pwm_x2),
	.pwm_y1     (res.pwm_y1),
	.pwm_y2     (res.pwm_y2),
	.total_power(res.total_power)
);
